>>> sv/scm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scm_pkg;
  // Default coordinate width (signed Q16.16 at 32)
  localparam int unsigned COORD_WIDTH = 32;
  // Vector components per query
  localparam int unsigned NUM_AXES = 3;
  // Query kinds carried on s_axis_tuser
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_SPHERE = 1'b1;
endpackage
`default_nettype wire

>>> sv/sphere_collision_mtv_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  tdata (low bit first)                                  tuser
// s_axis    in   sphere_x/y/z, sphere_radius, other_x/y/z,              kind
//                half_x/y/z, other_radius, zero pad to bytes
// m_axis    out  push_x, push_y, push_z, zero pad to bytes              hit, degenerate
//
// One request per clock enters while the pipeline advances: three front stages, one
// square-root stage per result bit, three setup stages, one divider stage per quotient
// bit, one output stage.
// rst clears only the valid bits. When the output register holds an untaken result
// the whole pipeline holds and s_axis_tready drops; an empty output register keeps it high.
module sphere_collision_mtv_top #(
  parameter int unsigned COORD_WIDTH = scm_pkg::COORD_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // sphere_x, sphere_y, sphere_z, sphere_radius, other_x, other_y, other_z,
  // half_x, half_y, half_z, other_radius
  input  wire logic [((11*COORD_WIDTH-5+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  wire logic [0:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // push_x, push_y, push_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // hit, degenerate
  output logic [1:0] m_axis_tuser
);
  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned NA    = scm_pkg::NUM_AXES;
  localparam int unsigned MW    = CW + 1;        // magnitude, limit, distance
  localparam int unsigned SW    = 2 * CW + 2;    // squares and products
  localparam int unsigned RRW   = CW + 4;        // square-root remainder
  localparam int unsigned DRW   = CW + 2;        // divider remainder
  localparam int unsigned OUT_W = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned NST   = 2 * CW + 8;

  typedef struct packed {
    logic [NA-1:0][MW-1:0] mag;
    logic [NA-1:0]         neg;
    logic [MW-1:0]         lim;
    logic                  hit;
  } sq_carry_t;

  typedef struct packed {
    logic [MW-1:0] dlen;
    logic [NA-1:0] neg;
    logic [NA-1:0] big;
    logic          hit;
    logic          degen;
  } dv_carry_t;

  logic           adv;
  logic [NST-1:0] vld;

  // Advance everything unless a finished result is stuck at the output
  assign adv           = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------- Stage 1: clamp and difference ----------------
  logic                  kind;
  logic [NA-1:0][MW-1:0] s1_mag;
  logic [NA-1:0]         s1_neg;
  logic [MW-1:0]         s1_lim;
  logic [CW-2:0]         r1, r2;

  assign kind = s_axis_tuser[0];
  assign r1   = s_axis_tdata[3*CW +: CW-1];
  assign r2   = s_axis_tdata[10*CW-4 +: CW-1];

  for (genvar i = 0; i < NA; i++) begin : g_diff
    logic        [CW-1:0] c, o;
    logic        [CW-2:0] h;
    logic signed [CW+1:0] cx, ox, lo, hi, p, d;
    assign c  = s_axis_tdata[i*CW +: CW];
    assign o  = s_axis_tdata[4*CW-1+i*CW +: CW];
    assign h  = s_axis_tdata[7*CW-1+i*(CW-1) +: CW-1];
    assign cx = {{2{c[CW-1]}}, c};
    assign ox = {{2{o[CW-1]}}, o};
    assign lo = ox - $signed({3'b000, h});
    assign hi = ox + $signed({3'b000, h});
    always_comb begin
      if (kind == scm_pkg::KIND_SPHERE) begin
        p = ox;
      end else if (cx < lo) begin
        p = lo;
      end else if (cx > hi) begin
        p = hi;
      end else begin
        p = cx;
      end
    end
    assign d = p - cx;
    always_ff @(posedge clk) begin
      if (adv) begin
        s1_neg[i] <= d[CW+1];
        s1_mag[i] <= d[CW+1] ? MW'(-d) : MW'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lim <= (kind == scm_pkg::KIND_SPHERE) ? ({2'b00, r1} + {2'b00, r2}) : {2'b00, r1};
    end
  end

  // ---------------- Stage 2: squares ----------------
  logic [NA-1:0][SW-1:0] s2_sq;
  logic [SW-1:0]         s2_limsq;
  sq_carry_t             s2_c;

  for (genvar i = 0; i < NA; i++) begin : g_sq
    logic [SW-1:0] prod;
    assign prod = s1_mag[i] * s1_mag[i];
    always_ff @(posedge clk) begin
      if (adv) begin
        s2_sq[i] <= prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_limsq  <= s1_lim * s1_lim;
      s2_c.mag  <= s1_mag;
      s2_c.neg  <= s1_neg;
      s2_c.lim  <= s1_lim;
      s2_c.hit  <= 1'b0;
    end
  end

  // ---------------- Stage 3: distance squared and hit test ----------------
  logic [SW-1:0] s3_dsq, dsq_sum;
  sq_carry_t     s3_c, s3_c_next;

  assign dsq_sum = s2_sq[0] + s2_sq[1] + s2_sq[2];

  always_comb begin
    s3_c_next     = s2_c;
    s3_c_next.hit = dsq_sum <= s2_limsq;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dsq <= dsq_sum;
      s3_c   <= s3_c_next;
    end
  end

  // ---------------- Square root: one result bit per stage ----------------
  logic [SW-1:0]  sq_n    [MW];
  logic [RRW-1:0] sq_rem  [MW];
  logic [MW-1:0]  sq_root [MW];
  sq_carry_t      sq_c    [MW];

  for (genvar k = 0; k < MW; k++) begin : g_sqrt
    logic [SW-1:0]  n_in;
    logic [RRW-1:0] rem_in, rsh, trial;
    logic [MW-1:0]  root_in;
    sq_carry_t      c_in;
    logic           ge;
    if (k == 0) begin : g_first
      assign n_in    = s3_dsq;
      assign rem_in  = '0;
      assign root_in = '0;
      assign c_in    = s3_c;
    end else begin : g_next
      assign n_in    = sq_n[k-1];
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign c_in    = sq_c[k-1];
    end
    assign rsh   = {rem_in[RRW-3:0], n_in[SW-1 -: 2]};
    assign trial = {{(RRW-MW-2){1'b0}}, root_in, 2'b01};
    assign ge    = rsh >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[k]    <= n_in << 2;
        sq_rem[k]  <= ge ? rsh - trial : rsh;
        sq_root[k] <= {root_in[MW-2:0], ge};
        sq_c[k]    <= c_in;
      end
    end
  end

  // ---------------- Stage P: penetration ----------------
  logic [NA-1:0][MW-1:0] p_mag;
  logic [MW-1:0]         p_pen;
  dv_carry_t             p_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mag     <= sq_c[MW-1].mag;
      p_pen     <= sq_c[MW-1].lim - sq_root[MW-1];
      p_c.dlen  <= sq_root[MW-1];
      p_c.neg   <= sq_c[MW-1].neg;
      p_c.big   <= '0;
      p_c.hit   <= sq_c[MW-1].hit;
      p_c.degen <= sq_root[MW-1] == '0;
    end
  end

  // ---------------- Stage M: scale by penetration ----------------
  logic [NA-1:0][SW-1:0] m_num;
  dv_carry_t             m_c;

  for (genvar i = 0; i < NA; i++) begin : g_scale
    logic [SW-1:0] prod;
    assign prod = p_mag[i] * p_pen;
    always_ff @(posedge clk) begin
      if (adv) begin
        m_num[i] <= prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_c <= p_c;
    end
  end

  // ---------------- Stage D0: overflow check and divider setup ----------------
  logic [NA-1:0][DRW-1:0] d0_rem;
  logic [NA-1:0][CW-1:0]  d0_n;
  dv_carry_t              d0_c, d0_c_next;
  logic [NA-1:0]          d0_big;

  for (genvar i = 0; i < NA; i++) begin : g_dsetup
    assign d0_big[i] = m_num[i][SW-1:CW] >= {1'b0, m_c.dlen};
    always_ff @(posedge clk) begin
      if (adv) begin
        d0_rem[i] <= m_num[i][SW-1:CW];
        d0_n[i]   <= m_num[i][CW-1:0];
      end
    end
  end

  always_comb begin
    d0_c_next     = m_c;
    d0_c_next.big = d0_big;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_c <= d0_c_next;
    end
  end

  // ---------------- Divider: one quotient bit per stage ----------------
  logic [NA-1:0][DRW-1:0] dv_rem [CW];
  logic [NA-1:0][CW-1:0]  dv_n   [CW];
  logic [NA-1:0][CW-1:0]  dv_q   [CW];
  dv_carry_t              dv_c   [CW];

  for (genvar j = 0; j < CW; j++) begin : g_div
    dv_carry_t c_in;
    if (j == 0) begin : g_first
      assign c_in = d0_c;
    end else begin : g_next
      assign c_in = dv_c[j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[j] <= c_in;
      end
    end
    for (genvar i = 0; i < NA; i++) begin : g_lane
      logic [DRW-1:0] rem_in, rsh, dsx;
      logic [CW-1:0]  n_in, q_in;
      logic           ge;
      if (j == 0) begin : g_first
        assign rem_in = d0_rem[i];
        assign n_in   = d0_n[i];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = dv_rem[j-1][i];
        assign n_in   = dv_n[j-1][i];
        assign q_in   = dv_q[j-1][i];
      end
      assign rsh = {rem_in[DRW-2:0], n_in[CW-1]};
      assign dsx = {1'b0, c_in.dlen};
      assign ge  = rsh >= dsx;
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[j][i] <= ge ? rsh - dsx : rsh;
          dv_n[j][i]   <= n_in << 1;
          dv_q[j][i]   <= {q_in[CW-2:0], ge};
        end
      end
    end
  end

  // ---------------- Output stage: sign, saturate, mask ----------------
  localparam logic [CW-1:0] SIGN_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] POS_MAX  = {1'b0, {(CW-1){1'b1}}};

  logic [NA-1:0][CW-1:0] o_push;
  logic                  o_hit, o_degen;
  dv_carry_t             fc;

  assign fc = dv_c[CW-1];

  for (genvar i = 0; i < NA; i++) begin : g_sat
    logic [CW-1:0] q, v;
    assign q = dv_q[CW-1][i];
    always_comb begin
      if (!fc.hit || fc.degen) begin
        v = '0;
      end else if (fc.neg[i]) begin
        v = (fc.big[i] || q > SIGN_MIN) ? SIGN_MIN : '0 - q;
      end else begin
        v = (fc.big[i] || q > POS_MAX) ? POS_MAX : q;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        o_push[i] <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_hit   <= fc.hit;
      o_degen <= fc.hit && fc.degen;
    end
  end

  assign m_axis_tdata = OUT_W'({o_push[2], o_push[1], o_push[0]});
  assign m_axis_tuser = {o_degen, o_hit};
endmodule
`default_nettype wire

>>> sv/scm_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module scm_chk #(
  parameter int unsigned COORD_WIDTH = scm_pkg::COORD_WIDTH
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic [((11*COORD_WIDTH-5+7)/8)*8-1:0] s_axis_tdata,
  input wire logic [0:0] s_axis_tuser,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser
);
  localparam int unsigned CW = COORD_WIDTH;

  // A stalled result stays valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A miss carries no vector and no degenerate flag
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[3*CW-1:0] == '0 && !m_axis_tuser[1])
    else $error("miss with nonzero push");

  // Degenerate is a hit with zero vector
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tuser[0] && m_axis_tdata[3*CW-1:0] == '0)
    else $error("degenerate result malformed");

  // Ready only drops behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");
endmodule

bind sphere_collision_mtv_top scm_chk #(.COORD_WIDTH(COORD_WIDTH)) u_scm_chk (.*);
`default_nettype wire
